@@ hw/rtl/lrs_pkg.sv @@
// Shared types and constants for the line rasterizer stepper.
package lrs_pkg;

  localparam int COORD_BITS   = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int SCREEN_BITS  = 15;
  localparam int PIXEL_BITS   = 15;
  localparam int COLOR_BITS   = 32;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 15'd1920;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 15'd1080;

  localparam logic [COLOR_BITS-1:0] COLOR_RAISED = 32'h00FF00FF;
  localparam logic [COLOR_BITS-1:0] COLOR_FLAT   = 32'hFFFFFFFF;

  // Operation codes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Decoded command flags carried through the queue.
  typedef struct packed {
    logic load;
    logic raised;
    logic dir_x_neg;
    logic dir_y_neg;
  } cmd_ctl_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hw/rtl/lrs_front.sv @@
// Front end: accepts input words, decodes them and precomputes line setup.
module lrs_front #(
  parameter int COORD_BITS = lrs_pkg::COORD_BITS
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic                         start_raised,
  input  logic                         end_raised,
  input  lrs_pkg::q_status_t           q_status,
  output logic                         push,
  output lrs_pkg::cmd_ctl_t            ctl,
  output logic [COORD_BITS-1:0]        span_x,
  output logic [COORD_BITS-1:0]        span_y
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] ax;
  logic signed [COORD_BITS:0] ay;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Spans are magnitudes of the endpoint differences; they fit the coordinate width.
  always_comb begin
    dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
    dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
    ax = dx[COORD_BITS] ? -dx : dx;
    ay = dy[COORD_BITS] ? -dy : dy;
    span_x = ax[COORD_BITS-1:0];
    span_y = ay[COORD_BITS-1:0];
    ctl.load      = (operation == lrs_pkg::OP_LOAD);
    ctl.raised    = start_raised || end_raised;
    ctl.dir_x_neg = (x_start >= x_end);
    ctl.dir_y_neg = (y_start >= y_end);
  end

endmodule

@@ hw/rtl/lrs_queue.sv @@
// Short first-in first-out queue between the front end and the back end.
module lrs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output lrs_pkg::q_status_t status
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/lrs_back.sv @@
// Back end: holds the line state, executes load and step words, drives the output register.
module lrs_back #(
  parameter int COORD_BITS = lrs_pkg::COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [lrs_pkg::SCREEN_BITS-1:0]     cfg_data,
  input  lrs_pkg::q_status_t                  q_status,
  output logic                                pop,
  input  lrs_pkg::cmd_ctl_t                   ctl,
  input  logic signed [COORD_BITS-1:0]        ld_cur_x,
  input  logic signed [COORD_BITS-1:0]        ld_cur_y,
  input  logic signed [COORD_BITS-1:0]        ld_end_x,
  input  logic signed [COORD_BITS-1:0]        ld_end_y,
  input  logic [COORD_BITS-1:0]               ld_span_x,
  input  logic [COORD_BITS-1:0]               ld_span_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lrs_pkg::PIXEL_BITS-1:0]      pixel_x,
  output logic [lrs_pkg::PIXEL_BITS-1:0]      pixel_y,
  output logic [lrs_pkg::COLOR_BITS-1:0]      pixel_color,
  output logic                                last
);

  localparam int E  = COORD_BITS + 3;
  localparam int SW = ((COORD_BITS > lrs_pkg::SCREEN_BITS) ? COORD_BITS
                                                           : lrs_pkg::SCREEN_BITS) + 1;

  logic [lrs_pkg::SCREEN_BITS-1:0] screen_width;
  logic [lrs_pkg::SCREEN_BITS-1:0] screen_height;

  logic signed [COORD_BITS-1:0] cur_x, cur_y, end_x, end_y;
  logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic [COORD_BITS-1:0]        span_x, span_y, span_x_next, span_y_next;
  logic                         dir_x_neg, dir_y_neg, dir_x_neg_next, dir_y_neg_next;
  logic signed [E-1:0]          error_term, error_term_next;
  logic                         raised, raised_next;
  logic                         line_active, line_active_next;

  logic                         out_free;
  logic                         emit;
  logic                         emit_last;
  logic signed [E-1:0]          sx_e, nsy_e;
  logic signed [E:0]            e2, sx_w, nsy_w;
  logic                         step_x, step_y;
  logic signed [COORD_BITS-1:0] step_cur_x, step_cur_y;
  logic signed [E-1:0]          step_err;
  logic                         step_done;

  function automatic logic on_screen(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic [lrs_pkg::SCREEN_BITS-1:0] w,
    input logic [lrs_pkg::SCREEN_BITS-1:0] h
  );
    return !x[COORD_BITS-1] && !y[COORD_BITS-1]
        && (SW'($unsigned(x)) < SW'(w)) && (SW'($unsigned(y)) < SW'(h));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lrs_pkg::SCREEN_WIDTH_RESET;
      screen_height <= lrs_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lrs_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        lrs_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = !q_status.empty && out_free;

  // One Bresenham step from the current state.
  always_comb begin
    sx_e       = E'({1'b0, span_x});
    nsy_e      = -E'({1'b0, span_y});
    sx_w       = (E+1)'({1'b0, span_x});
    nsy_w      = -(E+1)'({1'b0, span_y});
    e2         = {error_term, 1'b0};
    step_x     = (e2 >= nsy_w);
    step_y     = (e2 <= sx_w);
    step_err   = error_term + (step_x ? nsy_e : '0) + (step_y ? sx_e : '0);
    step_cur_x = step_x ? (dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
    step_cur_y = step_y ? (dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;
    step_done  = ((step_cur_x == end_x) && (step_cur_y == end_y))
              || !on_screen(step_cur_x, step_cur_y, screen_width, screen_height)
              || !on_screen(end_x, end_y, screen_width, screen_height);
  end

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    end_x_next       = end_x;
    end_y_next       = end_y;
    span_x_next      = span_x;
    span_y_next      = span_y;
    dir_x_neg_next   = dir_x_neg;
    dir_y_neg_next   = dir_y_neg;
    error_term_next  = error_term;
    raised_next      = raised;
    line_active_next = line_active;
    emit             = 1'b0;
    emit_last        = 1'b0;
    if (pop) begin
      if (ctl.load) begin
        cur_x_next       = ld_cur_x;
        cur_y_next       = ld_cur_y;
        end_x_next       = ld_end_x;
        end_y_next       = ld_end_y;
        span_x_next      = ld_span_x;
        span_y_next      = ld_span_y;
        dir_x_neg_next   = ctl.dir_x_neg;
        dir_y_neg_next   = ctl.dir_y_neg;
        error_term_next  = E'({1'b0, ld_span_x}) - E'({1'b0, ld_span_y});
        raised_next      = ctl.raised;
        line_active_next = ((ld_cur_x != ld_end_x) || (ld_cur_y != ld_end_y))
                        && on_screen(ld_cur_x, ld_cur_y, screen_width, screen_height)
                        && on_screen(ld_end_x, ld_end_y, screen_width, screen_height);
      end else if (line_active) begin
        if (((cur_x == end_x) && (cur_y == end_y))
            || !on_screen(cur_x, cur_y, screen_width, screen_height)
            || !on_screen(end_x, end_y, screen_width, screen_height)) begin
          line_active_next = 1'b0;
        end else begin
          emit             = 1'b1;
          emit_last        = step_done;
          cur_x_next       = step_cur_x;
          cur_y_next       = step_cur_y;
          error_term_next  = step_err;
          line_active_next = !step_done;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_x      <= cur_x_next;
    cur_y      <= cur_y_next;
    end_x      <= end_x_next;
    end_y      <= end_y_next;
    span_x     <= span_x_next;
    span_y     <= span_y_next;
    dir_x_neg  <= dir_x_neg_next;
    dir_y_neg  <= dir_y_neg_next;
    error_term <= error_term_next;
    raised     <= raised_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      line_active <= line_active_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      pixel_x     <= lrs_pkg::PIXEL_BITS'(cur_x);
      pixel_y     <= lrs_pkg::PIXEL_BITS'(cur_y);
      pixel_color <= raised ? lrs_pkg::COLOR_RAISED : lrs_pkg::COLOR_FLAT;
      last        <= emit_last;
    end
  end

endmodule

@@ hw/rtl/line_rasterizer_stepper.sv @@
// Top level of the Bresenham line rasterizer stepper.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | operation, x/y start, x/y end, raised flags
//  out     | output    | out_valid / out_stall| pixel_x, pixel_y, pixel_color, last
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// The block takes one input word per clock while in_stall is low and gives at most one
// pixel per clock. An accepted word waits in the queue until the back end pops and
// executes it, and its pixel is then registered in the output register; the rate is
// set by the combinational step unit in the back end.
// Reset makes the line idle and sets the screen to 1920 by 1080.
// A stall on the output holds the output register; words then gather in the
// four-entry queue, and only when it is full does in_stall rise.
module line_rasterizer_stepper #(
  parameter int COORD_BITS  = lrs_pkg::COORD_BITS,
  parameter int QUEUE_DEPTH = lrs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [lrs_pkg::SCREEN_BITS-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic signed [COORD_BITS-1:0]    x_start,
  input  logic signed [COORD_BITS-1:0]    y_start,
  input  logic signed [COORD_BITS-1:0]    x_end,
  input  logic signed [COORD_BITS-1:0]    y_end,
  input  logic                            start_raised,
  input  logic                            end_raised,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrs_pkg::PIXEL_BITS-1:0]  pixel_x,
  output logic [lrs_pkg::PIXEL_BITS-1:0]  pixel_y,
  output logic [lrs_pkg::COLOR_BITS-1:0]  pixel_color,
  output logic                            last
);

  // A queue word holds the decoded flags, both endpoints and both spans.
  localparam int CTL_BITS  = $bits(lrs_pkg::cmd_ctl_t);
  localparam int WORD_BITS = CTL_BITS + 6 * COORD_BITS;

  lrs_pkg::q_status_t    q_status;
  lrs_pkg::cmd_ctl_t     f_ctl, b_ctl;
  logic                  q_push, q_pop;
  logic [COORD_BITS-1:0] f_span_x, f_span_y;
  logic [WORD_BITS-1:0]  q_in, q_out;
  logic signed [COORD_BITS-1:0] b_cur_x, b_cur_y, b_end_x, b_end_y;
  logic [COORD_BITS-1:0] b_span_x, b_span_y;

  lrs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .x_start      (x_start),
    .y_start      (y_start),
    .x_end        (x_end),
    .y_end        (y_end),
    .start_raised (start_raised),
    .end_raised   (end_raised),
    .q_status     (q_status),
    .push         (q_push),
    .ctl          (f_ctl),
    .span_x       (f_span_x),
    .span_y       (f_span_y)
  );

  assign q_in = {f_ctl, x_start, y_start, x_end, y_end, f_span_x, f_span_y};

  lrs_queue #(.WIDTH(WORD_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  assign {b_ctl, b_cur_x, b_cur_y, b_end_x, b_end_y, b_span_x, b_span_y} = q_out;

  lrs_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .pop         (q_pop),
    .ctl         (b_ctl),
    .ld_cur_x    (b_cur_x),
    .ld_cur_y    (b_cur_y),
    .ld_end_x    (b_end_x),
    .ld_end_y    (b_end_y),
    .ld_span_x   (b_span_x),
    .ld_span_y   (b_span_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

`ifndef SYNTHESIS
  // The queue can never report full and empty together.
  a_q_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  // The back end never takes a word from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // The front end never writes into a full queue.
  a_push_notfull: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("push into full queue");

  // A stalled output with a full queue keeps the input stalled next cycle.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && q_status.full) |=> in_stall)
    else $error("input not stalled while queue full and output stalled");
`endif

endmodule

@@ tb/sv/tb_line_rasterizer_stepper.sv @@
// Self-checking testbench for the line rasterizer stepper, with its own line predictor.
module tb_line_rasterizer_stepper;

  // The run is stopped here if the block hangs.
  localparam int CYCLE_LIMIT = 200000;
  // Quiet cycles before a register write and at the end. Load words make no pixel, so up
  // to a full queue of them can still be in flight when the last pixel has arrived.
  localparam int SETTLE_CYCLES = lrs_pkg::QUEUE_DEPTH + 8;
  localparam int LAST_PHASE = 4;

  // One input word as driven on the ports.
  typedef struct packed {
    logic                                  op;
    logic signed [lrs_pkg::COORD_BITS-1:0] x0;
    logic signed [lrs_pkg::COORD_BITS-1:0] y0;
    logic signed [lrs_pkg::COORD_BITS-1:0] x1;
    logic signed [lrs_pkg::COORD_BITS-1:0] y1;
    logic                                  start_up;
    logic                                  end_up;
  } word_t;

  // One plotted pixel as seen on the output channel.
  typedef struct packed {
    logic [lrs_pkg::PIXEL_BITS-1:0] x;
    logic [lrs_pkg::PIXEL_BITS-1:0] y;
    logic [lrs_pkg::COLOR_BITS-1:0] color;
    logic                           last;
  } pixel_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic                            cfg_index;
  logic [lrs_pkg::SCREEN_BITS-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  word_t                           cur_word;
  logic                            out_valid;
  logic                            out_stall;
  logic [lrs_pkg::PIXEL_BITS-1:0]  pixel_x;
  logic [lrs_pkg::PIXEL_BITS-1:0]  pixel_y;
  logic [lrs_pkg::COLOR_BITS-1:0]  pixel_color;
  logic                            last;

  word_t  pending_words[$];
  pixel_t expected_pixels[$];
  pixel_t want;

  int errors = 0;
  int cycles = 0;
  int planned;
  int gap_left = 0;
  int stall_left = 0;
  int idle_odds = 8;
  bit word_taken = 1'b0;
  bit calm = 1'b0;
  bit quiet = 1'b0;

  // Predictor state: the screen size and the line being drawn.
  int                                    scr_w;
  int                                    scr_h;
  logic signed [lrs_pkg::COORD_BITS-1:0] pen_x, pen_y, goal_x, goal_y;
  int                                    span_x, neg_span_y, step_x, step_y, err_acc;
  logic                                  raised_line;
  logic                                  drawing;

  always #5 clk = ~clk;

  line_rasterizer_stepper dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (cur_word.op),
    .x_start     (cur_word.x0),
    .y_start     (cur_word.y0),
    .x_end       (cur_word.x1),
    .y_end       (cur_word.y1),
    .start_raised(cur_word.start_up),
    .end_raised  (cur_word.end_up),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last)
  );

  function automatic bit on_screen(input logic signed [lrs_pkg::COORD_BITS-1:0] x,
                                   input logic signed [lrs_pkg::COORD_BITS-1:0] y);
    return x >= 0 && y >= 0 && x < scr_w && y < scr_h;
  endfunction

  // The line can go on only while both its current point and its end are visible.
  function automatic bit line_visible();
    return on_screen(pen_x, pen_y) && on_screen(goal_x, goal_y);
  endfunction

  function automatic bit at_goal();
    return pen_x == goal_x && pen_y == goal_y;
  endfunction

  // Applies one accepted word to the predicted line and queues the pixel it yields, if any.
  task automatic predict_pixel(input word_t w);
    int     d;
    int     e2;
    pixel_t p;
    if (w.op == lrs_pkg::OP_LOAD) begin
      pen_x = w.x0;
      pen_y = w.y0;
      goal_x = w.x1;
      goal_y = w.y1;
      raised_line = w.start_up | w.end_up;
      d = goal_x - pen_x;
      span_x = (d < 0) ? -d : d;
      d = goal_y - pen_y;
      neg_span_y = (d < 0) ? d : -d;
      step_x = (pen_x < goal_x) ? 1 : -1;
      step_y = (pen_y < goal_y) ? 1 : -1;
      err_acc = span_x + neg_span_y;
      drawing = !at_goal() && line_visible();
    end else if (drawing) begin
      // The screen may have shrunk since the load; such a line dies without a pixel.
      if (at_goal() || !line_visible()) begin
        drawing = 1'b0;
      end else begin
        p.x = pen_x[lrs_pkg::PIXEL_BITS-1:0];
        p.y = pen_y[lrs_pkg::PIXEL_BITS-1:0];
        p.color = raised_line ? lrs_pkg::COLOR_RAISED : lrs_pkg::COLOR_FLAT;
        e2 = 2 * err_acc;
        if (e2 >= neg_span_y) begin
          err_acc += neg_span_y;
          pen_x = lrs_pkg::COORD_BITS'(pen_x + step_x);
        end
        if (e2 <= span_x) begin
          err_acc += span_x;
          pen_y = lrs_pkg::COORD_BITS'(pen_y + step_y);
        end
        if (at_goal() || !line_visible()) drawing = 1'b0;
        p.last = !drawing;
        expected_pixels.push_back(p);
      end
    end
  endtask

  task automatic add_word(input logic op, input int x0, input int y0, input int x1,
                          input int y1, input logic start_up, input logic end_up);
    word_t w;
    w.op = op;
    w.x0 = x0[lrs_pkg::COORD_BITS-1:0];
    w.y0 = y0[lrs_pkg::COORD_BITS-1:0];
    w.x1 = x1[lrs_pkg::COORD_BITS-1:0];
    w.y1 = y1[lrs_pkg::COORD_BITS-1:0];
    w.start_up = start_up;
    w.end_up = end_up;
    pending_words.push_back(w);
  endtask

  // Step words carry random coordinates and flags, which the block must ignore.
  task automatic add_step();
    add_word(lrs_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
             1'($urandom), 1'($urandom));
  endtask

  function automatic int clamp(input int v, input int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // A coordinate on screen, often close to one of the edges.
  function automatic int pick_coord(input int limit);
    int near;
    near = (limit > 16) ? 16 : limit;
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, near - 1);
      1: return limit - 1 - $urandom_range(0, near - 1);
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  // Queues a visible line of random direction, mostly short, then its steps. A full line
  // gets one step per pixel and sometimes one more, which lands on an idle block. A cut
  // line may stop early, so that the next load replaces it while it is still drawing.
  task automatic add_random_line(input bit cut);
    int len, x0, y0, x1, y1, major, n;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
    x0 = pick_coord(scr_w);
    y0 = pick_coord(scr_h);
    x1 = clamp(x0 + int'($urandom_range(0, 2 * len)) - len, scr_w - 1);
    y1 = clamp(y0 + int'($urandom_range(0, 2 * len)) - len, scr_h - 1);
    major = (x1 > x0) ? x1 - x0 : x0 - x1;
    if (((y1 > y0) ? y1 - y0 : y0 - y1) > major) major = (y1 > y0) ? y1 - y0 : y0 - y1;
    n = cut ? $urandom_range(0, major) : major + ($urandom_range(0, 3) == 0);
    add_word(lrs_pkg::OP_LOAD, x0, y0, x1, y1,
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (n) add_step();
    planned += 1 + n;
  endtask

  // Waits until every word is in and every pixel is out, then holds the output open for a
  // while so that trailing load words drain as well.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    quiet = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value[lrs_pkg::SCREEN_BITS-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == lrs_pkg::REG_SCREEN_WIDTH) scr_w = value;
    else scr_h = value;
  endtask

  // Input side. A word is taken at a rising edge with valid high and stall low; the next
  // word, or a gap, is put on the ports at the falling edge after it. A word that is
  // stalled stays on the ports unchanged.
  always @(negedge clk) begin
    if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid = 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_valid = 1'b1;
        if (!calm && $urandom_range(1, idle_odds) == 1) gap_left = $urandom_range(1, 9);
      end else begin
        in_valid = 1'b0;
      end
    end
  end

  // Output side stall, in bursts. It stays low while settling and in the final phase.
  always @(negedge clk) begin
    if (quiet || calm) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(1, idle_odds) == 1) stall_left = $urandom_range(1, 9);
    end
  end

  // Accepted input words feed the predictor at the same edge that the block takes them.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_pixel(cur_word);
      word_taken = 1'b1;
    end
  end

  // Every accepted pixel is checked against the oldest predicted one, field by field.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: x %0d, y %0d", pixel_x, pixel_y);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, actual %0d", want.x, pixel_x);
          errors++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, actual %0d", want.y, pixel_y);
          errors++;
        end
        if (pixel_color !== want.color) begin
          $error("pixel_color: expected %h, actual %h", want.color, pixel_color);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  // Stimulus. The run goes through five screen settings: the reset size, the smallest
  // screen, the largest one and two random ones. Each phase after the first starts with
  // a few steps, which continue or kill the line left drawing by the phase before, since
  // that line is now judged against the new screen size.
  initial begin
    int phase, w, h, budget, x0, y0, x1, y1;
    cur_word = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = lrs_pkg::REG_SCREEN_WIDTH;
    cfg_data = '0;
    scr_w = int'(lrs_pkg::SCREEN_WIDTH_RESET);
    scr_h = int'(lrs_pkg::SCREEN_HEIGHT_RESET);
    pen_x = '0;
    pen_y = '0;
    goal_x = '0;
    goal_y = '0;
    span_x = 0;
    neg_span_y = 0;
    step_x = 0;
    step_y = 0;
    err_acc = 0;
    raised_line = 1'b0;
    drawing = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words on the reset screen. A step right after reset finds no line.
    add_step();
    // A line of zero length draws nothing.
    add_word(lrs_pkg::OP_LOAD, 5, 5, 5, 5, 1'b0, 1'b0);
    add_step();
    // Extreme coordinates, far off screen.
    add_word(lrs_pkg::OP_LOAD, -32768, 0, 32767, 1079, 1'b1, 1'b1);
    add_step();
    // From the far corner back toward the origin, shallow; the extra step finds it done.
    add_word(lrs_pkg::OP_LOAD, 1919, 1079, 1917, 1078, 1'b1, 1'b0);
    repeat (3) add_step();
    // Steep, going up in both axes, end raised.
    add_word(lrs_pkg::OP_LOAD, 0, 0, 1, 2, 1'b0, 1'b1);
    repeat (2) add_step();
    // A new load while a line is drawing replaces it; the new one is vertical.
    add_word(lrs_pkg::OP_LOAD, 100, 100, 110, 100, 1'b0, 1'b0);
    add_step();
    add_word(lrs_pkg::OP_LOAD, 0, 5, 0, 1, 1'b1, 1'b1);
    repeat (4) add_step();
    // Start on screen but the end just past the bottom edge, or just left of column zero.
    add_word(lrs_pkg::OP_LOAD, 1919, 0, 1919, 1080, 1'b0, 1'b0);
    add_step();
    add_word(lrs_pkg::OP_LOAD, 3, 3, -1, 3, 1'b0, 1'b0);
    add_step();

    for (phase = 0; phase <= LAST_PHASE; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            w = 1;
            h = 1;
          end
          2: begin
            w = 32767;
            h = 32767;
          end
          3: begin
            w = $urandom_range(2, 100);
            h = $urandom_range(2, 100);
          end
          default: begin
            w = $urandom_range(16, 4000);
            h = $urandom_range(16, 4000);
          end
        endcase
        write_reg(lrs_pkg::REG_SCREEN_WIDTH, w);
        write_reg(lrs_pkg::REG_SCREEN_HEIGHT, h);
        quiet = 1'b0;
        repeat (3) add_step();
      end
      // Idling is heavy, light or rare per phase, and absent in the final one.
      case ($urandom_range(0, 2))
        0: idle_odds = 3;
        1: idle_odds = 10;
        default: idle_odds = 40;
      endcase
      calm = (phase == LAST_PHASE);
      budget = (phase == 1) ? 30 : 110;
      planned = 0;
      // Complete lines half the time; the rest are wild loads, stray steps, lines with one
      // endpoint just off the screen and lines cut short at a random step.
      while (planned < budget) begin
        case ($urandom_range(0, 7))
          0: begin
            add_word(lrs_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            add_step();
            planned += 2;
          end
          1: repeat ($urandom_range(1, 2)) add_step();
          2: begin
            x0 = pick_coord(scr_w);
            y0 = pick_coord(scr_h);
            x1 = pick_coord(scr_w);
            y1 = pick_coord(scr_h);
            case ($urandom_range(0, 3))
              0: x0 = $urandom_range(0, 1) ? -1 : scr_w;
              1: y0 = $urandom_range(0, 1) ? -1 : scr_h;
              2: x1 = $urandom_range(0, 1) ? -1 : scr_w;
              default: y1 = $urandom_range(0, 1) ? -1 : scr_h;
            endcase
            add_word(lrs_pkg::OP_LOAD, x0, y0, x1, y1,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            add_step();
            planned += 2;
          end
          3: add_random_line(1'b1);
          default: add_random_line(1'b0);
        endcase
      end
      // Leave a line drawing across the next register change.
      if (phase < LAST_PHASE) add_random_line(1'b1);
    end

    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_front.sv
hw/rtl/lrs_queue.sv
hw/rtl/lrs_back.sv
hw/rtl/line_rasterizer_stepper.sv
tb/sv/tb_line_rasterizer_stepper.sv
